/* sv/ddd_pkg.sv */
// Shared types and constants of the 3x3 depth discontinuity detector.
`timescale 1ns / 1ps
`default_nettype none

package ddd_pkg;

  // Depth samples and threshold are unsigned fixed point of this width.
  localparam int DEPTH_BITS = 24;
  localparam int CFG_DATA_W = 24;

  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_IMAGE_WIDTH     = 2'd0;
  localparam reg_idx_t REG_IMAGE_HEIGHT    = 2'd1;
  localparam reg_idx_t REG_DEPTH_THRESHOLD = 2'd2;

  // Configuration reset values.
  localparam logic [11:0] IMAGE_WIDTH_RST     = 12'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST    = 13'd480;
  localparam depth_t      DEPTH_THRESHOLD_RST = 24'd256;

  // Frame height limit and row counter ceiling.
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;
  localparam logic [12:0] ROW_CAP    = 13'd8191;

  // Input opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Result queue size.
  localparam int QDEPTH = 8;
  localparam int QAW    = 3;

  // Position and border information of one center pixel.
  typedef struct packed {
    logic [10:0] pixel_x;
    logic [11:0] pixel_y;
    logic        last;
    logic        lf;
    logic        rt;
    logic        up;
    logic        dn;
  } pix_tag_t;

  // One result item.
  typedef struct packed {
    logic        edge_res;
    logic [10:0] pixel_x;
    logic [11:0] pixel_y;
    logic        frame_last;
  } res_t;

endpackage

`default_nettype wire

/* sv/ddd_ram.sv */
// Generic simple dual-port RAM with registered read (read-first on collision).
`timescale 1ns / 1ps
`default_nettype none

module ddd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/depth_discontinuity_detector_3x3.sv */
// Top level of the 3x3 depth discontinuity detector.
//
//   Channel  Signals                                   Direction
//   cfg      cfg_we, cfg_addr, cfg_wdata               write only
//   in       in_valid/in_ready, opcode, depth          into the block
//   out      out_valid/out_ready, edge_res, pixel_x,   out of the block
//            pixel_y, frame_last
//
// One input transfer is taken per cycle. A result passes through the line store
// read, window shift, two min/max tree stages and the judge into an eight-entry
// result queue after the transfer that completes its window.
// Input stalls only when queued plus in-flight results fill that queue.
// Reset clears counters, window and configuration; the line stores need none.
`timescale 1ns / 1ps
`default_nettype none

module depth_discontinuity_detector_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire ddd_pkg::reg_idx_t   cfg_addr,
  input  wire ddd_pkg::cfg_data_t  cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                opcode,
  input  wire ddd_pkg::depth_t     depth,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     edge_res,
  output logic [10:0]              pixel_x,
  output logic [11:0]              pixel_y,
  output logic                     frame_last
);

  import ddd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  // Configuration registers.
  logic [11:0] image_width;
  logic [12:0] image_height;
  depth_t      depth_threshold;

  // Position counters.
  logic [CW-1:0] in_column, out_column;
  logic [12:0]   in_row, out_row;

  // Effective sizes and position decode.
  logic [WW-1:0] w_eff, col_inc, ox_inc;
  logic [12:0]   h_eff;
  logic [13:0]   oy_inc;
  logic          taking, take, emit, in_wrap, out_wrap, last;
  pix_tag_t      tag;

  // Stage A: line store read in flight.
  logic          a_valid, a_sample, a_emit, a_fwd;
  logic [CW-1:0] a_idx;
  depth_t        a_d;
  pix_tag_t      a_tag;
  depth_t        fwd_upper, fwd_middle;
  depth_t        upper_rd, middle_rd;
  depth_t        col_top, col_mid, col_bot;

  // Window and later stages.
  depth_t        win [9];
  logic          b_valid, c_valid, d_valid;
  pix_tag_t      b_tag, c_tag, d_tag;
  depth_t        nb [9];
  depth_t        c_center, d_center, d_min, d_max;
  depth_t        c_rmin [3];
  depth_t        c_rmax [3];
  logic          edge_now;

  // Result queue.
  res_t          q [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]  q_count;
  logic [QAW+1:0] busy;
  logic          push, pop;

  function automatic logic [12:0] row_inc(input logic [12:0] r);
    return (r >= ROW_CAP) ? ROW_CAP : r + 13'd1;
  endfunction

  function automatic depth_t dmin(input depth_t x, input depth_t y);
    return (y < x) ? y : x;
  endfunction

  function automatic depth_t dmax(input depth_t x, input depth_t y);
    return (y > x) ? y : x;
  endfunction

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= IMAGE_WIDTH_RST;
      image_height    <= IMAGE_HEIGHT_RST;
      depth_threshold <= DEPTH_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:     image_width     <= cfg_wdata[11:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_wdata[12:0];
        REG_DEPTH_THRESHOLD: depth_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the frame size into the supported range.
  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == 13'd0) begin
      h_eff = 13'd1;
    end else if (image_height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = image_height;
    end
  end

  // Decode the incoming transfer against the counters.
  always_comb begin
    taking   = in_row < h_eff;
    take     = in_valid && in_ready && ((opcode == OP_SAMPLE) ? taking : !taking);
    col_inc  = {1'b0, in_column} + WW'(1);
    in_wrap  = col_inc >= w_eff;
    emit     = (in_row >= 13'd2) || (in_row == 13'd1 && in_column != '0);
    ox_inc   = {1'b0, out_column} + WW'(1);
    out_wrap = ox_inc >= w_eff;
    oy_inc   = {1'b0, out_row} + 14'd1;
    last     = (oy_inc >= {1'b0, h_eff}) && out_wrap;
    tag.pixel_x = 11'(out_column);
    tag.pixel_y = out_row[11:0];
    tag.last    = last;
    tag.lf      = out_column != '0;
    tag.rt      = !out_wrap;
    tag.up      = out_row != 13'd0;
    tag.dn      = oy_inc < {1'b0, h_eff};
  end

  // Input and output position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= 13'd0;
      out_column <= '0;
      out_row    <= 13'd0;
    end else if (take) begin
      if (emit && last) begin
        in_column  <= '0;
        in_row     <= 13'd0;
        out_column <= '0;
        out_row    <= 13'd0;
      end else begin
        if (in_wrap) begin
          in_column <= '0;
          in_row    <= row_inc(in_row);
        end else begin
          in_column <= col_inc[CW-1:0];
        end
        if (emit) begin
          if (out_wrap) begin
            out_column <= '0;
            out_row    <= row_inc(out_row);
          end else begin
            out_column <= ox_inc[CW-1:0];
          end
        end
      end
    end
  end

  // Stage A control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= take;
    end
  end

  // Stage A payload, with forwarding of a write that the read just missed.
  always_ff @(posedge clk) begin
    if (take) begin
      a_sample   <= opcode == OP_SAMPLE;
      a_idx      <= in_column;
      a_d        <= depth;
      a_emit     <= emit;
      a_tag      <= tag;
      a_fwd      <= a_valid && a_sample && (a_idx == in_column);
      fwd_upper  <= col_mid;
      fwd_middle <= a_d;
    end
  end

  // New window column from the line stores and the sample.
  always_comb begin
    col_top = a_fwd ? fwd_upper : upper_rd;
    col_mid = a_fwd ? fwd_middle : middle_rd;
    col_bot = a_sample ? a_d : '0;
  end

  ddd_ram #(
    .WIDTH (DEPTH_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (a_valid && a_sample),
    .waddr (a_idx),
    .wdata (col_mid),
    .re    (take),
    .raddr (in_column),
    .rdata (upper_rd)
  );

  ddd_ram #(
    .WIDTH (DEPTH_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (a_valid && a_sample),
    .waddr (a_idx),
    .wdata (a_d),
    .re    (take),
    .raddr (in_column),
    .rdata (middle_rd)
  );

  // Window shift: each row moves left and takes the new column on the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (a_valid) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= col_top;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= col_mid;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= col_bot;
    end
  end

  // Neighbors outside the image take the center value.
  always_comb begin
    nb[4] = win[4];
    nb[0] = (b_tag.up && b_tag.lf) ? win[0] : win[4];
    nb[1] = b_tag.up ? win[1] : win[4];
    nb[2] = (b_tag.up && b_tag.rt) ? win[2] : win[4];
    nb[3] = b_tag.lf ? win[3] : win[4];
    nb[5] = b_tag.rt ? win[5] : win[4];
    nb[6] = (b_tag.dn && b_tag.lf) ? win[6] : win[4];
    nb[7] = b_tag.dn ? win[7] : win[4];
    nb[8] = (b_tag.dn && b_tag.rt) ? win[8] : win[4];
  end

  // Valid bits of stages B, C and D.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      b_valid <= a_valid && a_emit;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // Row min/max, then the final min/max of the window.
  always_ff @(posedge clk) begin
    b_tag    <= a_tag;
    c_tag    <= b_tag;
    c_center <= win[4];
    for (int r = 0; r < 3; r++) begin
      c_rmin[r] <= dmin(dmin(nb[3*r], nb[3*r+1]), nb[3*r+2]);
      c_rmax[r] <= dmax(dmax(nb[3*r], nb[3*r+1]), nb[3*r+2]);
    end
    d_tag    <= c_tag;
    d_center <= c_center;
    d_min    <= dmin(dmin(c_rmin[0], c_rmin[1]), c_rmin[2]);
    d_max    <= dmax(dmax(c_rmax[0], c_rmax[1]), c_rmax[2]);
  end

  // Threshold test of the center against the neighbor extremes.
  assign edge_now = ((d_center - d_min) > depth_threshold) ||
                    ((d_max - d_center) > depth_threshold);

  // Result queue; input is held back when queued and in-flight results fill it.
  assign push      = d_valid;
  assign pop       = out_valid && out_ready;
  assign out_valid = q_count != '0;
  assign busy      = (QAW+2)'(q_count) + (QAW+2)'(a_valid && a_emit) +
                     (QAW+2)'(b_valid) + (QAW+2)'(c_valid) + (QAW+2)'(d_valid);
  assign in_ready  = busy < (QAW+2)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      if (push && !pop) begin
        q_count <= q_count + (QAW+1)'(1);
      end else if (pop && !push) begin
        q_count <= q_count - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr].edge_res   <= edge_now;
      q[wptr].pixel_x    <= d_tag.pixel_x;
      q[wptr].pixel_y    <= d_tag.pixel_y;
      q[wptr].frame_last <= d_tag.last;
    end
  end

  // Head of the queue drives the output transfer.
  assign edge_res   = q[rptr].edge_res;
  assign pixel_x    = q[rptr].pixel_x;
  assign pixel_y    = q[rptr].pixel_y;
  assign frame_last = q[rptr].frame_last;

endmodule

`default_nettype wire

/* bench/depth_discontinuity_detector_3x3_tb.sv */
// Self-checking testbench that predicts the edge flag and position of every judged pixel.
`timescale 1ns / 1ps

module depth_discontinuity_detector_3x3_tb;
  import ddd_pkg::*;

  localparam int MAX_W          = 2048;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 4000;
  localparam int ITEMS_PER_MODE = 80;

  // Clock, reset and block ports.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  reg_idx_t    cfg_addr  = REG_IMAGE_WIDTH;
  cfg_data_t   cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        opcode    = OP_SAMPLE;
  depth_t      depth     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        edge_res;
  logic [10:0] pixel_x;
  logic [11:0] pixel_y;
  logic        frame_last;

  // Predictor copy of configuration, line stores, window and position counters.
  logic [11:0] cfg_width  = IMAGE_WIDTH_RST;
  logic [12:0] cfg_height = IMAGE_HEIGHT_RST;
  depth_t      cfg_thresh = DEPTH_THRESHOLD_RST;
  depth_t      line_upper  [MAX_W] = '{default: '0};
  depth_t      line_middle [MAX_W] = '{default: '0};
  depth_t      window_px   [9]     = '{default: '0};
  logic [10:0] in_col  = '0;
  logic [10:0] out_col = '0;
  logic [12:0] in_row  = '0;
  logic [12:0] out_row = '0;
  res_t        edge_results_q [$];
  res_t        head;

  // Run control shared by the stimulus, the receiver and the checker.
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_asked    = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int unsigned taken_items   = 0;
  int unsigned quiet_cycles  = 0;
  int          fail_count    = 0;

  depth_discontinuity_detector_3x3 u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .depth      (depth),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .edge_res   (edge_res),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .frame_last (frame_last)
  );

  initial forever #10 clk = ~clk;

  // Effective frame sizes: zero counts as one, oversize values are clamped.
  function automatic int unsigned span_w();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_W) return MAX_W;
    return 32'(cfg_width);
  endfunction

  function automatic int unsigned span_h();
    if (cfg_height == 0) return 1;
    if (cfg_height > MAX_HEIGHT) return 32'(MAX_HEIGHT);
    return 32'(cfg_height);
  endfunction

  function automatic logic [12:0] next_row(logic [12:0] r);
    return (r >= ROW_CAP) ? ROW_CAP : r + 13'd1;
  endfunction

  // Shift the 3x3 window left by one column and insert the new column on the right.
  function automatic void shift_window(depth_t top, depth_t mid, depth_t bot);
    depth_t col_in [3];
    int k;
    col_in[0] = top;
    col_in[1] = mid;
    col_in[2] = bot;
    for (k = 0; k < 3; k++) begin
      window_px[3*k]   = window_px[3*k+1];
      window_px[3*k+1] = window_px[3*k+2];
      window_px[3*k+2] = col_in[k];
    end
  endfunction

  // Advance the predictor by one accepted transfer and queue the result it causes.
  // Returns 0 when the block ignores the transfer.
  function automatic bit predict_edge_result(logic op, depth_t d);
    int unsigned w, h;
    int          k;
    logic        emit, lf, rt, up, dn, last;
    logic [8:0]  nb_used;
    depth_t      c, mn, mx;
    res_t        r;
    w = span_w();
    h = span_h();
    if (op == OP_SAMPLE) begin
      if (in_row >= h) return 1'b0;
      shift_window(line_upper[in_col], line_middle[in_col], d);
      line_upper[in_col]  = line_middle[in_col];
      line_middle[in_col] = d;
    end else begin
      if (in_row < h) return 1'b0;
      shift_window(line_upper[in_col], line_middle[in_col], '0);
    end
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= w) begin
      in_col = '0;
      in_row = next_row(in_row);
    end else begin
      in_col = in_col + 11'd1;
    end
    if (!emit) return 1'b1;

    // Neighbors outside the image are replaced by the center, so they are skipped.
    lf = out_col > 0;
    rt = out_col + 1 < w;
    up = out_row > 0;
    dn = out_row + 1 < h;
    nb_used = {dn && rt, dn, dn && lf, rt, 1'b0, lf, up && rt, up, up && lf};
    c  = window_px[4];
    mn = c;
    mx = c;
    for (k = 0; k < 9; k++) begin
      if (nb_used[k]) begin
        if (window_px[k] < mn) mn = window_px[k];
        if (window_px[k] > mx) mx = window_px[k];
      end
    end
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    r.edge_res   = ((c - mn) > cfg_thresh) || ((mx - c) > cfg_thresh);
    r.pixel_x    = out_col;
    r.pixel_y    = out_row[11:0];
    r.frame_last = last;
    edge_results_q = {edge_results_q, r};

    // The last pixel of a frame restarts all position counters.
    if (last) begin
      in_col  = '0;
      in_row  = '0;
      out_col = '0;
      out_row = '0;
    end else if (out_col + 1 >= w) begin
      out_col = '0;
      out_row = next_row(out_row);
    end else begin
      out_col = out_col + 11'd1;
    end
    return 1'b1;
  endfunction

  // Mostly a smooth surface around a base depth, now and then a far or extreme sample.
  function automatic depth_t scene_depth(depth_t base, int unsigned spread);
    case ($urandom_range(19))
      0: return depth_t'($urandom);
      1: return '0;
      2: return '1;
      default: return base + depth_t'($urandom_range(spread));
    endcase
  endfunction

  // Offer one item and hold it until the transfer, then maybe leave a gap.
  task automatic send_item(input logic op, input depth_t d);
    in_valid <= 1'b1;
    opcode   <= op;
    depth    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_edge_result(op, d)) taken_items++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stop offering and wait until every predicted result is back and the pipeline is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (edge_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write, then cfg_we is low again before the next write, so that writes never overlap.
  task automatic write_reg(input reg_idx_t idx, input cfg_data_t val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:     cfg_width  = val[11:0];
      REG_IMAGE_HEIGHT:    cfg_height = val[12:0];
      REG_DEPTH_THRESHOLD: cfg_thresh = val[DEPTH_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_frame(input cfg_data_t w, input cfg_data_t h, input cfg_data_t thr);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_DEPTH_THRESHOLD, thr);
  endtask

  // Flush until the frame's last result is predicted; stray samples are dropped by the block.
  task automatic drain_frame(input bit noisy);
    while (in_row >= span_h()) begin
      if (noisy && $urandom_range(99) < 8) send_item(OP_SAMPLE, depth_t'($urandom));
      send_item(OP_FLUSH, depth_t'($urandom));
    end
  endtask

  // Send the rest of the current frame, then drain it; stray flushes are ignored by the block.
  task automatic finish_frame(input depth_t base, input int unsigned spread, input bit noisy);
    while (in_row < span_h()) begin
      if (noisy && $urandom_range(99) < 4) send_item(OP_FLUSH, depth_t'($urandom));
      send_item(OP_SAMPLE, scene_depth(base, spread));
    end
    drain_frame(noisy);
  endtask

  // Width and threshold keep their reset values; only the height is shortened.
  // After one full line and the first result the line is narrowed while idle,
  // so that the frame ends after one more result.
  task automatic test_reset_values();
    depth_t base;
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, 24'd1);
    base = depth_t'($urandom);
    repeat (int'(IMAGE_WIDTH_RST)) send_item(OP_SAMPLE, scene_depth(base, 512));
    // The first flush only moves the drain on; the second judges the first pixel.
    send_item(OP_FLUSH, '0);
    send_item(OP_FLUSH, '0);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 24'd2);
    drain_frame(1'b0);
  endtask

  // Extreme depths, both opcodes, ignored and dropped items, zero sizes.
  task automatic test_directed_corners();
    depth_t corner_px [9];
    corner_px = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h555555, 24'hAAAAAA,
                  24'h000001, 24'hFFFFFF, 24'hFFFFFE, 24'h7FFFFF};
    wait_drained();
    set_frame(24'd3, 24'd3, 24'd0);
    // A flush while samples are still expected has no effect.
    send_item(OP_FLUSH, 24'hFFFFFF);
    foreach (corner_px[i]) send_item(OP_SAMPLE, corner_px[i]);
    // A sample after the frame is taken is dropped.
    send_item(OP_SAMPLE, 24'h123456);
    drain_frame(1'b0);

    // Zero width and height act as a single pixel; the first flush gives no result.
    wait_drained();
    set_frame(24'd0, 24'd0, 24'hFFFFFF);
    send_item(OP_FLUSH, 24'h000000);
    send_item(OP_SAMPLE, 24'hFFFFFF);
    drain_frame(1'b0);
  endtask

  // Threshold and width change in the middle of a frame, with the block idle.
  task automatic test_mid_frame_change();
    depth_t base;
    wait_drained();
    set_frame(24'd8, 24'd6, 24'd300);
    base = depth_t'($urandom);
    repeat (16) send_item(OP_SAMPLE, scene_depth(base, 600));
    wait_drained();
    write_reg(REG_DEPTH_THRESHOLD, 24'd50);
    repeat (8) send_item(OP_SAMPLE, scene_depth(base, 600));
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 24'd5);
    finish_frame(base, 600, 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_back_pressure();
    wait_drained();
    set_frame(24'd12, 24'd6, cfg_data_t'($urandom_range(0, 400)));
    hold_asked++;
    finish_frame(depth_t'($urandom), 400, 1'b0);
  endtask

  // Register writes keep only the low bits of each size field.
  task automatic test_register_truncation();
    wait_drained();
    set_frame(24'hABC004, 24'h7FE003, cfg_data_t'($urandom_range(0, 2000)));
    finish_frame(depth_t'($urandom), 2000, 1'b0);
    wait_drained();
    set_frame(24'h123007, 24'h45A002, 24'hFFFFFF);
    finish_frame(depth_t'($urandom), 2000, 1'b0);
  endtask

  // Whole frames of random small sizes, thresholds and surfaces, with stray items mixed in.
  task automatic test_random_frames(input int unsigned budget);
    int unsigned stop_at, spread, w;
    cfg_data_t   thr;
    stop_at = taken_items + budget;
    while (taken_items < stop_at) begin
      wait_drained();
      spread = 1 << $urandom_range(0, 12);
      case ($urandom_range(7))
        0: thr = '0;
        1: thr = '1;
        default: thr = cfg_data_t'($urandom_range(0, spread));
      endcase
      w = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      set_frame(cfg_data_t'(w), cfg_data_t'($urandom_range(1, 8)), thr);
      finish_frame(depth_t'($urandom), spread, 1'b1);
    end
  endtask

  // Result receiver: random stalls, plus a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (edge_results_q.size() == 0) begin
        $error("result with nothing predicted: x=%0d y=%0d", pixel_x, pixel_y);
        fail_count++;
      end else begin
        head = edge_results_q.pop_front();
        check_field("edge_res", 12'(head.edge_res), 12'(edge_res));
        check_field("pixel_x", 12'(head.pixel_x), 12'(pixel_x));
        check_field("pixel_y", head.pixel_y, pixel_y);
        check_field("frame_last", 12'(head.frame_last), 12'(frame_last));
      end
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence: three idling modes in turn.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 54;
    test_reset_values();
    test_directed_corners();
    test_random_frames(ITEMS_PER_MODE);

    send_idle_pct = 54;
    recv_idle_pct = 34;
    test_mid_frame_change();
    test_back_pressure();
    test_random_frames(ITEMS_PER_MODE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_register_truncation();
    test_random_frames(ITEMS_PER_MODE);

    wait_drained();
    if (fail_count == 0 && edge_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
